/* hw/rtl/smx_pkg.sv */
// ---------------------------------------------------------------------------
// smx_pkg: shared types and constants of the SplitMix bounded integer block
// Command codes, mixer constants, and the command and status records that
// pass between the sequencer and the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smx_pkg;

  // Request kinds carried in the input tuser field.
  localparam logic [1:0] CMD_RAW     = 2'd0;
  localparam logic [1:0] CMD_BOOL    = 2'd1;
  localparam logic [1:0] CMD_UNIFORM = 2'd2;
  localparam logic [1:0] CMD_LOG     = 2'd3;

  // Mixer constants and the reset increment.
  localparam logic [63:0] MixC1      = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MixC2      = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] GammaReset = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] Mask63     = 64'h7fffffffffffffff;
  localparam int unsigned MixShift   = 33;

  // Bit-length search: six halving steps, then one closing step.
  localparam logic [2:0] BlenLast = 3'd6;

  // Operations that the sequencer asks of the datapath in one cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_BLEN,
    OP_DIFF,
    OP_SEED,
    OP_MIX,
    OP_MUL_START,
    OP_XS,
    OP_FULL,
    OP_DIV_START,
    OP_ADDLO,
    OP_LOG2,
    OP_OUT
  } smx_op_e;

  // Source of the value placed in the output register.
  typedef enum logic [1:0] {
    SRC_RAW,
    SRC_BOOL,
    SRC_RES,
    SRC_ZERO
  } smx_src_e;

  typedef struct packed {
    smx_op_e    op;
    logic [2:0] step;
    logic       mul_sel;
    smx_src_e   src;
    logic       err;
  } smx_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       range_err;
    logic       full_span;
    logic       accept;
    logic       log_empty;
    logic       mul_done;
    logic       div_done;
    logic       out_free;
  } smx_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/smx_mul.sv */
// ---------------------------------------------------------------------------
// smx_mul: iterative 64 x 64 multiplier, low half of the product
// Builds the low 64 bits from three 32 x 32 partial products, one per cycle,
// with a register after each multiplication.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smx_mul import smx_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic      [63:0] prod_o,
  output logic             done_o
);

  localparam logic [1:0] StepLast = 2'd3;

  logic [63:0] a_q, b_q, pp_q, acc_q;
  logic [1:0]  step_q;
  logic        busy_q, done_q;
  logic [31:0] op_a, op_b;
  logic [63:0] prod_w;

  // Step 0 takes lo*lo, step 1 hi*lo, step 2 lo*hi; only the low 32 bits of
  // the cross terms reach the result.
  assign op_a   = (step_q == 2'd1) ? a_q[63:32] : a_q[31:0];
  assign op_b   = (step_q == 2'd2) ? b_q[63:32] : b_q[31:0];
  assign prod_w = 64'(op_a) * 64'(op_b);

  // Control: step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (step_q == StepLast);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == StepLast) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Operands, partial product and accumulator.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      pp_q <= prod_w;
      if (step_q == 2'd1) begin
        acc_q <= pp_q;
      end else if (step_q != 2'd0) begin
        acc_q <= acc_q + {pp_q[31:0], 32'b0};
      end
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

/* hw/rtl/smx_div.sv */
// ---------------------------------------------------------------------------
// smx_div: restoring remainder unit for 63-bit operands
// Produces dividend mod divisor one bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smx_div import smx_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [62:0] dividend_i,
  input  wire logic [62:0] divisor_i,
  output logic      [62:0] rem_o,
  output logic             done_o
);

  localparam logic [5:0] BitLast = 6'd62;

  logic [62:0] dvd_q, dvs_q, rem_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [63:0] trial, diff;

  // Bring down the next dividend bit and subtract where it fits.
  assign trial = {rem_q, dvd_q[62]};
  assign diff  = trial - {1'b0, dvs_q};

  // Control: bit counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == BitLast);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == BitLast) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Partial remainder and shifting dividend.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= 63'd0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[61:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_q <= diff[62:0];
      end else begin
        rem_q <= trial[62:0];
      end
    end
  end

  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

/* hw/rtl/smx_datapath.sv */
// ---------------------------------------------------------------------------
// smx_datapath: registers, mixer and range arithmetic
// Holds the configuration and running seed, the request bounds, the draw,
// the range working registers and the output register, and carries out
// one sequencer operation per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smx_datapath import smx_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire smx_cmd_t     cmd_i,
  output smx_sts_t          sts_o,
  input  wire logic [127:0] in_data_i,
  input  wire logic [1:0]   in_user_i,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_sel_i,
  input  wire logic [63:0]  cfg_wdata_i,
  output logic      [63:0]  cfg_rdata_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic      [63:0]  out_data_o,
  output logic              out_err_o
);

  function automatic logic [63:0] sext63(input logic [62:0] v);
    return {v[62], v};
  endfunction

  logic [63:0] gamma_q, seed_start_q, seed_q;
  logic [1:0]  req_q;
  logic [63:0] lo_q, hi_q, a_q, b_q, top_q, lim_q, z_q, rres_q;
  logic [62:0] d_q, tl_q, th_q;
  logic [5:0]  nl_q, nh_q;
  logic [63:0] out_data_q;
  logic        out_err_q, out_valid_q;

  logic [63:0] lo_ext, hi_ext, mul_prod;
  logic [62:0] div_rem, tl_sh, th_sh;
  logic [5:0]  blen_k, nb;
  logic [63:0] lower, upper;
  logic        mul_done, div_done;

  assign lo_ext = sext63(in_data_i[62:0]);
  assign hi_ext = sext63(in_data_i[125:63]);

  // Shared arithmetic units.
  smx_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_MUL_START),
    .a_i     (z_q),
    .b_i     (cmd_i.mul_sel ? MixC2 : MixC1),
    .prod_o  (mul_prod),
    .done_o  (mul_done)
  );

  smx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == OP_DIV_START),
    .dividend_i (z_q[62:0]),
    .divisor_i  (top_q[62:0] + 63'd1),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  // Bit-length search: shift by 32, 16, ... 1 where the upper part is nonzero.
  assign blen_k = 6'd32 >> cmd_i.step;
  assign tl_sh  = tl_q >> blen_k;
  assign th_sh  = th_q >> blen_k;

  // Range of values that have exactly nb significant bits.
  assign nb    = rres_q[5:0];
  assign lower = (nb == 6'd0) ? 64'd0 : (64'd1 << (nb - 6'd1));
  assign upper = (64'd1 << nb) - 64'd1;

  // Configuration and running seed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q      <= GammaReset;
      seed_start_q <= 64'd0;
      seed_q       <= 64'd0;
    end else if (cfg_we_i) begin
      if (cfg_sel_i) begin
        seed_start_q <= cfg_wdata_i;
        seed_q       <= cfg_wdata_i;
      end else begin
        gamma_q <= {cfg_wdata_i[63:1], 1'b1};
      end
    end else if (cmd_i.op == OP_SEED) begin
      seed_q <= seed_q + gamma_q;
    end
  end

  assign cfg_rdata_o = cfg_sel_i ? seed_start_q : gamma_q;

  // Working registers of the request.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        req_q <= in_user_i;
        lo_q  <= lo_ext;
        hi_q  <= hi_ext;
        a_q   <= lo_ext;
        b_q   <= hi_ext;
        tl_q  <= lo_ext[63] ? 63'd0 : lo_ext[62:0];
        th_q  <= hi_ext[63] ? 63'd0 : hi_ext[62:0];
        nl_q  <= 6'd0;
        nh_q  <= 6'd0;
      end
      OP_BLEN: begin
        if (cmd_i.step == BlenLast) begin
          a_q <= {58'd0, nl_q + {5'd0, |tl_q}};
          b_q <= {58'd0, nh_q + {5'd0, |th_q}};
        end else begin
          if (tl_sh != 63'd0) begin
            tl_q <= tl_sh;
            nl_q <= nl_q + blen_k;
          end
          if (th_sh != 63'd0) begin
            th_q <= th_sh;
            nh_q <= nh_q + blen_k;
          end
        end
      end
      OP_DIFF: begin
        top_q <= b_q - a_q;
      end
      OP_MIX: begin
        z_q <= seed_q ^ (seed_q >> MixShift);
      end
      OP_XS: begin
        z_q <= mul_prod ^ (mul_prod >> MixShift);
      end
      OP_FULL: begin
        rres_q <= sext63(63'({1'b0, z_q[62:0]} + a_q));
      end
      OP_DIV_START: begin
        d_q   <= z_q[62:0];
        lim_q <= Mask63 - top_q;
      end
      OP_ADDLO: begin
        rres_q <= sext63(63'({1'b0, div_rem} + a_q));
      end
      OP_LOG2: begin
        a_q <= ($signed(lo_q) < $signed(lower)) ? lower : lo_q;
        b_q <= ($signed(upper) < $signed(hi_q)) ? upper : hi_q;
      end
      default: begin
      end
    endcase
  end

  // Output register: loaded on a finished request, emptied by a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_OUT) begin
      out_err_q <= cmd_i.err;
      case (cmd_i.src)
        SRC_RAW:  out_data_q <= z_q;
        SRC_BOOL: out_data_q <= {63'd0, z_q[0]};
        SRC_RES:  out_data_q <= rres_q;
        SRC_ZERO: out_data_q <= 64'd0;
        default:  out_data_q <= 64'd0;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_err_o   = out_err_q;

  // Status toward the sequencer.
  always_comb begin
    sts_o.cmd       = req_q;
    sts_o.range_err = ($signed(hi_q) < $signed(lo_q)) || ((req_q == CMD_LOG) && hi_q[63]);
    sts_o.full_span = (top_q == Mask63);
    sts_o.accept    = (({1'b0, d_q} - {1'b0, div_rem}) <= lim_q);
    sts_o.log_empty = ($signed(b_q) < $signed(a_q));
    sts_o.mul_done  = mul_done;
    sts_o.div_done  = div_done;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

/* hw/rtl/smx_ctrl.sv */
// ---------------------------------------------------------------------------
// smx_ctrl: request sequencer
// Steps each request through loading, bound checks, bit-length search,
// draws, rejection loop and result hand-off, at most one datapath operation a cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smx_ctrl import smx_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output smx_cmd_t      cmd_o,
  input  wire smx_sts_t sts_i
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_BLEN      = 4'd2;
  localparam logic [3:0] S_DIFF      = 4'd3;
  localparam logic [3:0] S_SEED      = 4'd4;
  localparam logic [3:0] S_MIX       = 4'd5;
  localparam logic [3:0] S_MUL1_GO   = 4'd6;
  localparam logic [3:0] S_MUL1_WAIT = 4'd7;
  localparam logic [3:0] S_MUL2_GO   = 4'd8;
  localparam logic [3:0] S_MUL2_WAIT = 4'd9;
  localparam logic [3:0] S_POST      = 4'd10;
  localparam logic [3:0] S_DIV_WAIT  = 4'd11;
  localparam logic [3:0] S_RES       = 4'd12;
  localparam logic [3:0] S_LOGCHK    = 4'd13;
  localparam logic [3:0] S_OUT       = 4'd14;

  logic [3:0] state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pass_q, pass_d;
  smx_src_e   src_q, src_d;
  logic       err_q, err_d;

  // Next state and the operation issued this cycle.
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    pass_d        = pass_q;
    src_d         = src_q;
    err_d         = err_q;
    in_ready_o    = 1'b0;
    cmd_o.op      = OP_NONE;
    cmd_o.step    = cnt_q;
    cmd_o.mul_sel = 1'b0;
    cmd_o.src     = src_q;
    cmd_o.err     = err_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          pass_d   = 1'b0;
          cnt_d    = 3'd0;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        err_d = 1'b0;
        case (sts_i.cmd)
          CMD_RAW: begin
            src_d   = SRC_RAW;
            state_d = S_SEED;
          end
          CMD_BOOL: begin
            src_d   = SRC_BOOL;
            state_d = S_SEED;
          end
          CMD_UNIFORM, CMD_LOG: begin
            if (sts_i.range_err) begin
              src_d   = SRC_ZERO;
              err_d   = 1'b1;
              state_d = S_OUT;
            end else begin
              src_d   = SRC_RES;
              state_d = (sts_i.cmd == CMD_LOG) ? S_BLEN : S_DIFF;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_BLEN: begin
        cmd_o.op = OP_BLEN;
        cnt_d    = cnt_q + 3'd1;
        if (cnt_q == BlenLast) begin
          cnt_d   = 3'd0;
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = S_SEED;
      end
      S_SEED: begin
        cmd_o.op = OP_SEED;
        state_d  = S_MIX;
      end
      S_MIX: begin
        cmd_o.op = OP_MIX;
        state_d  = S_MUL1_GO;
      end
      S_MUL1_GO: begin
        cmd_o.op = OP_MUL_START;
        state_d  = S_MUL1_WAIT;
      end
      S_MUL1_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.op = OP_XS;
          state_d  = S_MUL2_GO;
        end
      end
      S_MUL2_GO: begin
        cmd_o.op      = OP_MUL_START;
        cmd_o.mul_sel = 1'b1;
        state_d       = S_MUL2_WAIT;
      end
      S_MUL2_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.op = OP_XS;
          state_d  = S_POST;
        end
      end
      S_POST: begin
        if (src_q != SRC_RES) begin
          state_d = S_OUT;
        end else if (sts_i.full_span) begin
          cmd_o.op = OP_FULL;
          state_d  = S_RES;
        end else begin
          cmd_o.op = OP_DIV_START;
          state_d  = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          if (sts_i.accept) begin
            cmd_o.op = OP_ADDLO;
            state_d  = S_RES;
          end else begin
            // Biased draw: take another one.
            state_d = S_SEED;
          end
        end
      end
      S_RES: begin
        if ((sts_i.cmd == CMD_LOG) && !pass_q) begin
          cmd_o.op = OP_LOG2;
          pass_d   = 1'b1;
          state_d  = S_LOGCHK;
        end else begin
          state_d = S_OUT;
        end
      end
      S_LOGCHK: begin
        if (sts_i.log_empty) begin
          src_d   = SRC_ZERO;
          state_d = S_OUT;
        end else begin
          state_d = S_DIFF;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 3'd0;
      pass_q  <= 1'b0;
      src_q   <= SRC_ZERO;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pass_q  <= pass_d;
      src_q   <= src_d;
      err_q   <= err_d;
    end
  end

  // A result is written only when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_OUT) |-> sts_i.out_free)
    else $error("result written into an occupied output register");

  // Multiplier completions arrive only while a draw waits for them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |-> (state_q == S_MUL1_WAIT || state_q == S_MUL2_WAIT))
    else $error("multiplier finished outside a draw");

  // Divider completions arrive only while the rejection check waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_DIV_WAIT))
    else $error("divider finished outside the rejection check");

  // Only range requests use the divider.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_WAIT) |-> (sts_i.cmd == CMD_UNIFORM || sts_i.cmd == CMD_LOG))
    else $error("divider in use for a raw or boolean request");

endmodule

`default_nettype wire

/* hw/rtl/splitmix_bounded_int_generator.sv */
// ---------------------------------------------------------------------------
// splitmix_bounded_int_generator: SplitMix-style bounded draws, fmix64 mixer
// Answers each request with a raw draw, a boolean, a uniform integer in a
// range, or a log-uniform integer, using rejection to remove bias.
// ---------------------------------------------------------------------------
//
// Channel   Dir  Payload
// s_axis    in   tdata: range_low [62:0], range_high [125:63]; tuser: command
// m_axis    out  tdata: draw_value [63:0]; tuser: range_error
// apb       in   gamma at 0x0, seed_start at 0x8, 64-bit data
//
// Raw and boolean requests make two passes through the iterative multiplier.
// A uniform request also runs its draw through the one-bit-a-cycle remainder
// unit unless its range spans the full 63-bit width; a rejected draw is
// replaced by a fresh draw. Log-uniform requests add a bit-length search
// and a second range.
// Reset restores gamma and clears seed_start and the running seed; a new
// request is taken while a finished result still waits on m_axis.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module splitmix_bounded_int_generator import smx_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Request stream.
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [127:0] s_axis_tdata_i,  // range_low, range_high, zero pad
  input  wire logic [1:0]   s_axis_tuser_i,  // command
  // Result stream.
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic      [63:0]  m_axis_tdata_o,  // draw_value
  output logic              m_axis_tuser_o,  // range_error
  // Register port.
  input  wire logic         psel_i,
  input  wire logic         penable_i,
  input  wire logic         pwrite_i,
  input  wire logic [3:0]   paddr_i,
  input  wire logic [63:0]  pwdata_i,
  output logic      [63:0]  prdata_o,
  output logic              pready_o
);

  smx_cmd_t cmd;
  smx_sts_t sts;
  logic     cfg_we;

  // Register writes complete in the access phase; no wait states.
  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i && pready_o;

  smx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  smx_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .cfg_we_i    (cfg_we),
    .cfg_sel_i   (paddr_i[3]),
    .cfg_wdata_i (pwdata_i),
    .cfg_rdata_o (prdata_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_err_o   (m_axis_tuser_o)
  );

endmodule

`default_nettype wire
